/* hdl/wmbs_pkg.sv */
// Shared constants and types for the weighted moving-mean
// background subtractor. No dependencies.
`timescale 1ns / 1ps

package wmbs_pkg;

    localparam int PIX_W        = 8;
    localparam int FRAME_PIXELS = 524288;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_PIXELS - 1);

    // frames completed, saturating at two
    localparam int FRAMES_W = 2;
    localparam logic [FRAMES_W-1:0] FRAMES_NONE = 2'd0;
    localparam logic [FRAMES_W-1:0] FRAMES_FULL = 2'd2;

    // Rounded-sum width: 5*255 + 3*255 + 2*255 + 5 = 2555
    localparam int SUM_W = 12;

    // Division by reciprocal: floor(n*1639 >> 14) = n/10 for n <= 2555,
    // floor(n*683 >> 11) = n/3 for n <= 766
    localparam int RECIP_W = 11;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 11'd1639;
    localparam logic [RECIP_W-1:0] RECIP_THREE = 11'd683;
    localparam int SHIFT_TEN   = 14;
    localparam int SHIFT_THREE = 11;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHTED_MODE    = 2'd0,
        CFG_THRESHOLD_ENABLE = 2'd1,
        CFG_THRESHOLD_LEVEL  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             weighted_mode;
        logic             threshold_enable;
        logic [PIX_W-1:0] threshold_level;
    } cfg_t;

    // pixel and its two co-sited history samples leaving the fetch stage
    typedef struct packed {
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] p1;
        logic [PIX_W-1:0] p2;
    } fetch_item_t;

endpackage

/* hdl/wmbs_intf.sv */
// Stream and configuration channel interfaces for the background subtractor.
// Depends on wmbs_pkg.
`timescale 1ns / 1ps

interface wmbs_pix_if;
    logic                       valid;
    logic                       ready;
    logic [wmbs_pkg::PIX_W-1:0] pixel;
    logic                       frame_end;

    modport source (output valid, output pixel, output frame_end, input ready);
    modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

interface wmbs_res_if;
    logic                       valid;
    logic                       ready;
    logic [wmbs_pkg::PIX_W-1:0] foreground;
    logic [wmbs_pkg::PIX_W-1:0] background;

    modport source (output valid, output foreground, output background, input ready);
    modport sink   (input valid, input foreground, input background, output ready);
endinterface

interface wmbs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wmbs_pkg::CFG_IDX_W-1:0] index;
    logic [wmbs_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/wmbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/wmbs_frame_store.sv */
// Fetch stage: pixel address counter, frame count, the two history frame
// stores and write-to-read forwarding. Depends on wmbs_pkg, wmbs_intf, wmbs_ram.
`timescale 1ns / 1ps

module wmbs_frame_store (
    input  logic                  clk,
    input  logic                  rst_n,
    wmbs_pix_if.sink              pixels,
    output logic                  fetch_valid,
    input  logic                  fetch_ready,
    output wmbs_pkg::fetch_item_t fetch_item
);

    logic [wmbs_pkg::ADDR_W-1:0]   addr_reg;
    logic [wmbs_pkg::ADDR_W-1:0]   addr_next;
    logic [wmbs_pkg::FRAMES_W-1:0] frames_reg;
    logic [wmbs_pkg::FRAMES_W-1:0] frames_next;

    logic                          s1_valid_reg;
    logic [wmbs_pkg::PIX_W-1:0]    s1_cur_reg;
    logic [wmbs_pkg::ADDR_W-1:0]   s1_addr_reg;
    logic [wmbs_pkg::FRAMES_W-1:0] s1_frames_reg;
    logic                          fwd_hit_reg;
    logic [wmbs_pkg::PIX_W-1:0]    fwd_p1_reg;
    logic [wmbs_pkg::PIX_W-1:0]    fwd_p2_reg;

    logic                          accept;
    logic                          s1_result;
    logic                          s1_leave;
    logic [wmbs_pkg::PIX_W-1:0]    rd_p1;
    logic [wmbs_pkg::PIX_W-1:0]    rd_p2;
    logic [wmbs_pkg::PIX_W-1:0]    p1_eff;
    logic [wmbs_pkg::PIX_W-1:0]    p2_eff;
    logic [wmbs_pkg::PIX_W-1:0]    p2_wdata;
    logic                          p2_we;

    assign s1_result    = s1_valid_reg && (s1_frames_reg == wmbs_pkg::FRAMES_FULL);
    assign s1_leave     = s1_valid_reg && (!s1_result || fetch_ready);
    assign pixels.ready = !s1_valid_reg || s1_leave;
    assign accept       = pixels.valid && pixels.ready;

    // Next address and frame count
    always_comb
    begin
        addr_next   = addr_reg;
        frames_next = frames_reg;
        if (pixels.frame_end)
        begin
            addr_next = '0;
            if (frames_reg != wmbs_pkg::FRAMES_FULL)
            begin
                frames_next = frames_reg + 1'b1;
            end
        end
        else if (addr_reg == wmbs_pkg::LAST_ADDR)
        begin
            addr_next = '0;
        end
        else
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            frames_reg   <= wmbs_pkg::FRAMES_NONE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                addr_reg   <= addr_next;
                frames_reg <= frames_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_leave)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // A read issued on the edge the previous pixel writes the same address
    // sees the old entry: take the written values instead.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg    <= pixels.pixel;
            s1_addr_reg   <= addr_reg;
            s1_frames_reg <= frames_reg;
            fwd_hit_reg   <= s1_leave && (s1_addr_reg == addr_reg);
            fwd_p1_reg    <= s1_cur_reg;
            fwd_p2_reg    <= p2_wdata;
        end
    end

    assign p1_eff   = fwd_hit_reg ? fwd_p1_reg : rd_p1;
    assign p2_eff   = fwd_hit_reg ? fwd_p2_reg : rd_p2;
    assign p2_we    = s1_leave && (s1_frames_reg != wmbs_pkg::FRAMES_NONE);
    assign p2_wdata = (s1_frames_reg != wmbs_pkg::FRAMES_NONE) ? p1_eff : p2_eff;

    wmbs_ram #(
        .WIDTH (wmbs_pkg::PIX_W),
        .DEPTH (wmbs_pkg::FRAME_PIXELS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (s1_leave),
        .waddr (s1_addr_reg),
        .wdata (s1_cur_reg),
        .re    (accept),
        .raddr (addr_reg),
        .rdata (rd_p1)
    );

    wmbs_ram #(
        .WIDTH (wmbs_pkg::PIX_W),
        .DEPTH (wmbs_pkg::FRAME_PIXELS)
    ) u_prev2_ram (
        .clk   (clk),
        .we    (p2_we),
        .waddr (s1_addr_reg),
        .wdata (p2_wdata),
        .re    (accept),
        .raddr (addr_reg),
        .rdata (rd_p2)
    );

    assign fetch_valid     = s1_result;
    assign fetch_item.cur  = s1_cur_reg;
    assign fetch_item.p1   = p1_eff;
    assign fetch_item.p2   = p2_eff;

endmodule

/* hdl/wmbs_datapath.sv */
// Arithmetic pipeline: rounded sum, reciprocal divide, difference and
// threshold into the output register. Depends on wmbs_pkg, wmbs_intf.
`timescale 1ns / 1ps

module wmbs_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wmbs_pkg::cfg_t        cfg,
    input  logic                  fetch_valid,
    output logic                  fetch_ready,
    input  wmbs_pkg::fetch_item_t fetch_item,
    wmbs_res_if.source            results
);

    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;
    logic                         r1;
    logic                         r2;
    logic                         r3;

    logic [wmbs_pkg::SUM_W-1:0]   sum_next;
    logic [wmbs_pkg::SUM_W-1:0]   sum_reg;
    logic [wmbs_pkg::PIX_W-1:0]   c1_reg;
    logic [wmbs_pkg::PROD_W-1:0]  prod_next;
    logic [wmbs_pkg::PROD_W-1:0]  prod_reg;
    logic [wmbs_pkg::PIX_W-1:0]   c2_reg;
    logic [wmbs_pkg::PIX_W-1:0]   bg_next;
    logic [wmbs_pkg::PIX_W-1:0]   diff;
    logic [wmbs_pkg::PIX_W-1:0]   fg_next;
    logic [wmbs_pkg::PIX_W-1:0]   fg_reg;
    logic [wmbs_pkg::PIX_W-1:0]   bg_reg;

    assign r3          = !v3_reg || results.ready;
    assign r2          = !v2_reg || r3;
    assign r1          = !v1_reg || r2;
    assign fetch_ready = r1;

    always_comb
    begin
        if (cfg.weighted_mode)
        begin
            sum_next = wmbs_pkg::SUM_W'(fetch_item.cur) * wmbs_pkg::SUM_W'(5)
                     + wmbs_pkg::SUM_W'(fetch_item.p1) * wmbs_pkg::SUM_W'(3)
                     + wmbs_pkg::SUM_W'(fetch_item.p2) * wmbs_pkg::SUM_W'(2)
                     + wmbs_pkg::SUM_W'(5);
        end
        else
        begin
            sum_next = wmbs_pkg::SUM_W'(fetch_item.cur)
                     + wmbs_pkg::SUM_W'(fetch_item.p1)
                     + wmbs_pkg::SUM_W'(fetch_item.p2)
                     + wmbs_pkg::SUM_W'(1);
        end
    end

    assign prod_next = wmbs_pkg::PROD_W'(sum_reg)
                     * wmbs_pkg::PROD_W'(cfg.weighted_mode ? wmbs_pkg::RECIP_TEN
                                                            : wmbs_pkg::RECIP_THREE);

    assign bg_next = cfg.weighted_mode ? prod_reg[wmbs_pkg::SHIFT_TEN +: wmbs_pkg::PIX_W]
                                       : prod_reg[wmbs_pkg::SHIFT_THREE +: wmbs_pkg::PIX_W];
    assign diff    = (c2_reg > bg_next) ? (c2_reg - bg_next) : (bg_next - c2_reg);

    always_comb
    begin
        fg_next = diff;
        if (cfg.threshold_enable)
        begin
            fg_next = (diff > cfg.threshold_level) ? '1 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= fetch_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && fetch_valid)
        begin
            sum_reg <= sum_next;
            c1_reg  <= fetch_item.cur;
        end
        if (r2 && v1_reg)
        begin
            prod_reg <= prod_next;
            c2_reg   <= c1_reg;
        end
        if (r3 && v2_reg)
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    assign results.valid      = v3_reg;
    assign results.foreground = fg_reg;
    assign results.background = bg_reg;

endmodule

/* hdl/weighted_moving_mean_background_subtract.sv */
// Top level of the three-frame weighted moving-mean background subtractor.
// Depends on wmbs_pkg, wmbs_intf, wmbs_frame_store, wmbs_datapath.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload                      Transaction when
//  --------  ---------  ---------------------------  ------------------
//  pixels    in         pixel[7:0], frame_end        valid && ready
//  results   out        foreground[7:0], bkg[7:0]    valid && ready
//  cfg       in         index[1:0], data[7:0]        valid && ready
//
//  One pixel per cycle sustained while results are taken; a result is registered
//  through the fetch, sum, divide and output registers after its pixel transaction.
//  The rate is set by the single read port of each frame store, read once per pixel.
//  Reset clears the address counter, the frame count and the valid bits and resets the
//  configuration registers; the frame stores are not cleared and need no clearing pass.
//  Stalls on results ripple back stage by stage; pixels.ready drops only when
//  every stage holds a result.

module weighted_moving_mean_background_subtract (
    input  logic       clk,
    input  logic       rst_n,
    wmbs_pix_if.sink   pixels,
    wmbs_res_if.source results,
    wmbs_cfg_if.sink   cfg
);

    wmbs_pkg::cfg_t        cfg_reg;
    logic                  fetch_valid;
    logic                  fetch_ready;
    wmbs_pkg::fetch_item_t fetch_item;

    // Configuration writes never stall
    assign cfg.ready = 1'b1;

    // Decode register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weighted_mode    <= 1'b1;
            cfg_reg.threshold_enable <= 1'b1;
            cfg_reg.threshold_level  <= 8'd15;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (wmbs_pkg::cfg_reg_t'(cfg.index))
                wmbs_pkg::CFG_WEIGHTED_MODE:
                begin
                    cfg_reg.weighted_mode <= cfg.data[0];
                end
                wmbs_pkg::CFG_THRESHOLD_ENABLE:
                begin
                    cfg_reg.threshold_enable <= cfg.data[0];
                end
                wmbs_pkg::CFG_THRESHOLD_LEVEL:
                begin
                    cfg_reg.threshold_level <= cfg.data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Fetch: address the history stores and hand on pixels from the third
    // frame onwards; earlier frames only fill the stores.
    wmbs_frame_store u_frame_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .fetch_valid (fetch_valid),
        .fetch_ready (fetch_ready),
        .fetch_item  (fetch_item)
    );

    // Arithmetic: rounded mean, divide by reciprocal, difference, threshold
    wmbs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fetch_valid (fetch_valid),
        .fetch_ready (fetch_ready),
        .fetch_item  (fetch_item),
        .results     (results)
    );

endmodule

/* hdl/wmbs_checker.sv */
// Port-level checks for the background subtractor, bound to the top level.
// Depends on the top-level ports only.
`timescale 1ns / 1ps

module wmbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_fg,
    input logic [7:0] out_bg,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_fg) && $stable(out_bg))
        else $error("result changed while stalled");

    // Drop valid only after a completed transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result withdrawn without transaction");

    // Input back-pressure only when the output side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output free");

    // Configuration writes are always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind weighted_moving_mean_background_subtract wmbs_checker u_wmbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_fg    (results.foreground),
    .out_bg    (results.background),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);
